### hw/rtl/rlfcd_pkg.sv
`default_nettype none

package rlfcd_pkg;

	localparam int BUFFER_BYTES_DEF = 64;
	localparam int NUM_CH           = 16;
	localparam int RAW_BITS         = 11;
	localparam int ACC_BITS         = 18;

	// raw * 0.62477 + 881 in Q16
	localparam logic [15:0] SCALE_Q16  = 16'd40945;
	localparam logic [27:0] OFFSET_Q16 = 28'd57737216;

	localparam logic [11:0] RESET_US     = 12'd1500;
	localparam logic [7:0]  SYNC_RST     = 8'd200;
	localparam logic [7:0]  TYPE_RST     = 8'd22;
	localparam logic [15:0] TIMEOUT_RST  = 16'd500;
	localparam logic [11:0] FAILSAFE_RST = 12'd1500;

	localparam logic [4:0] FIRST_DATA_BYTE = 5'd3;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [1:0] REG_SYNC     = 2'd0;
	localparam logic [1:0] REG_TYPE     = 2'd1;
	localparam logic [1:0] REG_TIMEOUT  = 2'd2;
	localparam logic [1:0] REG_FAILSAFE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_LD,
		ST_EXT,
		ST_MUL,
		ST_CRD
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  channel;
		logic [11:0] value_us;
		logic        link_ok;
		logic        last;
	} out_item_t;

endpackage

`default_nettype wire

### hw/rtl/rlfcd_ram.sv
`default_nettype none

module rlfcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/rc_link_frame_channel_decoder.sv
// Channel   Handshake                   Payload
// in        in_valid / in_ready         in_data   (kind, data)
// out       out_valid / out_ready       out_data  (channel, value_us, link_ok, last)
// cfg       psel penable pwrite pready  paddr pwdata prdata
//
// A channel read waits in a read state until the output register is free, then loads the
// registered channel memory output into it. A byte that completes a channel frame holds
// the input for 22 buffer reads, each a read and a load state, through the single read
// port of the frame memory, then an extract and a scale state per channel, plus output stalls.
// Reset clears control state and the valid bits; unwritten memory entries read as zero
// (frame bytes) or 1500 (channel values). The output register lets a new request in
// while a result waits to be taken.
`default_nettype none

module rc_link_frame_channel_decoder #(
	parameter int BUFFER_BYTES = rlfcd_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire rlfcd_pkg::in_item_t   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output rlfcd_pkg::out_item_t       out_data,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [3:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	import rlfcd_pkg::*;

	localparam int AW  = $clog2(BUFFER_BYTES);
	localparam int CHW = $clog2(NUM_CH);

	state_t state_q, state_d;

	logic [AW-1:0]       idx_q;
	logic [7:0]          len_q;
	logic [7:0]          type_q;
	logic [15:0]         ms_q;
	logic [7:0]          sync_q;
	logic [7:0]          rctype_q;
	logic [15:0]         timeout_q;
	logic [11:0]         failsafe_q;
	logic [BUFFER_BYTES-1:0] buf_vld_q;
	logic [NUM_CH-1:0]   ch_vld_q;
	logic [4:0]          rd_byte_q;
	logic [ACC_BITS-1:0] acc_q;
	logic [4:0]          nbits_q;
	logic [CHW-1:0]      ch_q;
	logic [RAW_BITS-1:0] raw_q;
	logic [CHW-1:0]      rch_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic          in_acc, is_byte, is_tick, is_read;
	logic [9:0]    idx_inc, len_end;
	logic [7:0]    byte2;
	logic          frame_end, overflow, start_dec;
	logic          buf_we;
	logic [7:0]    buf_rdata;
	logic [AW-1:0] buf_raddr;
	logic [7:0]    byte_ld;
	logic [4:0]    nbits_ld;
	logic [27:0]   prod;
	logic [11:0]   scaled;
	logic [11:0]   ch_rdata;
	logic [11:0]   read_val;
	logic          link_ok;
	logic          out_free, load_dec, load_rd;
	logic          cfg_we;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign is_byte  = in_acc && (in_data.kind == KIND_BYTE);
	assign is_tick  = in_acc && (in_data.kind == KIND_TICK);
	assign is_read  = in_acc && (in_data.kind == KIND_READ);

	assign idx_inc   = 10'(idx_q) + 10'd1;
	assign len_end   = 10'(len_q) + 10'd2;
	assign byte2     = (idx_q == AW'(2)) ? in_data.data : type_q;
	assign frame_end = (idx_inc >= len_end);
	assign overflow  = (idx_inc >= 10'(BUFFER_BYTES));
	assign start_dec = is_byte && (idx_q >= AW'(2)) && frame_end && (byte2 == rctype_q);
	assign buf_we    = is_byte && ((idx_q != '0) || (in_data.data == sync_q));
	assign buf_raddr = AW'(rd_byte_q);

	assign link_ok  = (ms_q < timeout_q);
	assign byte_ld  = buf_vld_q[buf_raddr] ? buf_rdata : 8'd0;
	assign nbits_ld = nbits_q + 5'd8;
	assign prod     = 28'(raw_q) * 28'(SCALE_Q16) + OFFSET_Q16;
	assign scaled   = prod[27:16];
	assign read_val = link_ok ? (ch_vld_q[rch_q] ? ch_rdata : RESET_US) : failsafe_q;
	assign out_free = !out_valid_q || out_ready;

	rlfcd_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_buf_ram (
		.clk  (clk),
		.we   (buf_we),
		.waddr(idx_q),
		.wdata(in_data.data),
		.raddr(buf_raddr),
		.rdata(buf_rdata)
	);

	// a stalled read keeps re-reading its own channel
	rlfcd_ram #(
		.WIDTH(12),
		.DEPTH(NUM_CH)
	) u_ch_ram (
		.clk  (clk),
		.we   (load_dec),
		.waddr(ch_q),
		.wdata(scaled),
		.raddr((state_q == ST_CRD) ? rch_q : in_data.data[CHW-1:0]),
		.rdata(ch_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_dec = 1'b0;
		load_rd  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start_dec) begin
					state_d = ST_RD;
				end else if (is_read) begin
					state_d = ST_CRD;
				end
			end
			ST_RD: begin
				state_d = ST_LD;
			end
			ST_LD: begin
				state_d = (nbits_ld >= 5'(RAW_BITS)) ? ST_EXT : ST_RD;
			end
			ST_EXT: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (out_free) begin
					load_dec = 1'b1;
					if (ch_q == CHW'(NUM_CH - 1)) begin
						state_d = ST_IDLE;
					end else if (nbits_q >= 5'(RAW_BITS)) begin
						state_d = ST_EXT;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_CRD: begin
				if (out_free) begin
					load_rd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// frame assembly, link age and configuration
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			len_q      <= '0;
			ms_q       <= '0;
			buf_vld_q  <= '0;
			sync_q     <= SYNC_RST;
			rctype_q   <= TYPE_RST;
			timeout_q  <= TIMEOUT_RST;
			failsafe_q <= FAILSAFE_RST;
		end else begin
			if (buf_we) begin
				buf_vld_q[idx_q] <= 1'b1;
			end
			if (is_byte) begin
				if (idx_q == '0) begin
					if (in_data.data == sync_q) begin
						idx_q <= AW'(1);
					end
				end else if (idx_q == AW'(1)) begin
					len_q <= in_data.data;
					idx_q <= AW'(2);
				end else if (frame_end || overflow) begin
					idx_q <= '0;
					len_q <= '0;
				end else begin
					idx_q <= idx_inc[AW-1:0];
				end
			end
			if (start_dec) begin
				ms_q <= '0;
			end else if (is_tick && (ms_q != 16'hFFFF)) begin
				ms_q <= ms_q + 16'd1;
			end
			if (cfg_we) begin
				unique case (paddr[3:2])
					REG_SYNC:     sync_q     <= pwdata[7:0];
					REG_TYPE:     rctype_q   <= pwdata[7:0];
					REG_TIMEOUT:  timeout_q  <= pwdata[15:0];
					REG_FAILSAFE: failsafe_q <= pwdata[11:0];
					default:      ;
				endcase
			end
		end
	end

	// decode sequencer and channel store valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_byte_q   <= '0;
			nbits_q     <= '0;
			ch_q        <= '0;
			ch_vld_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_dec) begin
				rd_byte_q <= FIRST_DATA_BYTE;
				nbits_q   <= '0;
				ch_q      <= '0;
			end
			if (state_q == ST_LD) begin
				nbits_q   <= nbits_ld;
				rd_byte_q <= rd_byte_q + 5'd1;
			end
			if (state_q == ST_EXT) begin
				nbits_q <= nbits_q - 5'(RAW_BITS);
			end
			if (load_dec) begin
				ch_vld_q[ch_q] <= 1'b1;
				ch_q           <= ch_q + CHW'(1);
			end
			if (load_dec || load_rd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_dec) begin
			acc_q <= '0;
		end
		if (is_byte && (idx_q == AW'(2))) begin
			type_q <= in_data.data;
		end
		if (is_read) begin
			rch_q <= in_data.data[CHW-1:0];
		end
		if (state_q == ST_LD) begin
			acc_q <= acc_q | (ACC_BITS'(byte_ld) << nbits_q);
		end
		if (state_q == ST_EXT) begin
			raw_q <= acc_q[RAW_BITS-1:0];
			acc_q <= acc_q >> RAW_BITS;
		end
		if (load_dec) begin
			out_q.channel  <= 4'(ch_q);
			out_q.value_us <= scaled;
			out_q.link_ok  <= link_ok;
			out_q.last     <= (ch_q == CHW'(NUM_CH - 1));
		end else if (load_rd) begin
			out_q.channel  <= 4'(rch_q);
			out_q.value_us <= read_val;
			out_q.link_ok  <= link_ok;
			out_q.last     <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pready    = 1'b1;

	always_comb begin
		unique case (paddr[3:2])
			REG_SYNC:     prdata = {24'd0, sync_q};
			REG_TYPE:     prdata = {24'd0, rctype_q};
			REG_TIMEOUT:  prdata = {16'd0, timeout_q};
			REG_FAILSAFE: prdata = {20'd0, failsafe_q};
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/rlfcd_checker.sv
`default_nettype none

module rlfcd_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire rlfcd_pkg::out_item_t out_data
);

	// only the final channel of a frame, or a read, carries last
	a_nonlast_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.channel != 4'd15)
		else $error("non-final result on channel 15");

	// scaled values cannot exceed the scaled top of the 11-bit raw range
	a_scaled_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.value_us <= 12'd2159)
		else $error("scaled value out of range");

	// while a frame is still being emitted no new request is taken
	a_busy_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> !in_ready)
		else $error("input taken in the middle of a frame");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind rc_link_frame_channel_decoder rlfcd_checker u_rlfcd_checker (.*);

`default_nettype wire

### tb/sv/rc_link_frame_channel_decoder_tb.sv
`timescale 1ns / 100ps

module rc_link_frame_channel_decoder_tb;

	import rlfcd_pkg::*;

	localparam int FRAME_MEM     = 64;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 120;
	localparam int FILL_ZERO     = 0;
	localparam int FILL_ONES     = 1;
	localparam int FILL_RAND     = 2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	in_item_t    in_data   = '0;
	logic        out_ready = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	wire         in_ready;
	wire         out_valid;
	out_item_t   out_data;
	wire  [31:0] prdata;
	wire         pready;

	rc_link_frame_channel_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder shadow: frame memory, parser position, channel values, link age
	logic [7:0]  rx_bytes [FRAME_MEM];
	int          rx_idx;
	int          rx_len;
	logic [11:0] pulse_store [16];
	logic [15:0] link_age;
	logic [7:0]  cfg_sync;
	logic [7:0]  cfg_type;
	logic [15:0] cfg_timeout;
	logic [11:0] cfg_failsafe;

	out_item_t pulse_q [$];
	in_item_t  request_q [$];

	int   n_queued   = 0;
	int   n_taken    = 0;
	int   n_errors   = 0;
	int   n_cycles   = 0;
	logic req_taken  = 1'b0;
	int   gap_left   = 0;
	int   burst_left = 1;
	int   stall_left = 0;
	logic stall_mode = 1'b1;

	logic [7:0] sync_now = SYNC_RST;
	logic [7:0] type_now = TYPE_RST;

	initial begin
		for (int i = 0; i < FRAME_MEM; i++)
			rx_bytes[i] = 8'd0;
		for (int i = 0; i < 16; i++)
			pulse_store[i] = 12'd1500;
		rx_idx       = 0;
		rx_len       = 0;
		link_age     = 16'd0;
		cfg_sync     = 8'd200;
		cfg_type     = 8'd22;
		cfg_timeout  = 16'd500;
		cfg_failsafe = 12'd1500;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		n_errors++;
	endtask

	function automatic logic link_up();
		return link_age < cfg_timeout;
	endfunction

	task automatic unpack_channels();
		logic [175:0] bits;
		int unsigned  raw;
		out_item_t    e;
		for (int i = 0; i < 22; i++)
			bits[8*i +: 8] = rx_bytes[3 + i];
		for (int c = 0; c < 16; c++) begin
			raw = 32'(bits[11*c +: 11]);
			// 0.62477 in Q16, offset 881 us
			raw = (raw * 32'd40945 + (32'd881 << 16)) >> 16;
			pulse_store[c] = raw[11:0];
		end
		link_age = 16'd0;
		for (int c = 0; c < 16; c++) begin
			e.channel  = c[3:0];
			e.value_us = pulse_store[c];
			e.link_ok  = link_up();
			e.last     = (c == 15);
			pulse_q.push_back(e);
		end
	endtask

	task automatic take_serial_byte(input logic [7:0] b);
		if (rx_idx == 0) begin
			if (b == cfg_sync) begin
				rx_bytes[0] = b;
				rx_idx = 1;
			end
		end else if (rx_idx == 1) begin
			rx_len = 32'(b);
			rx_bytes[1] = b;
			rx_idx = 2;
		end else begin
			if (rx_idx < FRAME_MEM)
				rx_bytes[rx_idx] = b;
			rx_idx++;
			if (rx_idx >= rx_len + 2) begin
				if (rx_bytes[2] == cfg_type)
					unpack_channels();
				rx_idx = 0;
				rx_len = 0;
			end
			if (rx_idx >= FRAME_MEM) begin
				rx_idx = 0;
				rx_len = 0;
			end
		end
	endtask

	task automatic decode_request(input in_item_t req);
		out_item_t e;
		case (req.kind)
			KIND_BYTE: take_serial_byte(req.data);
			KIND_TICK: if (link_age != 16'hFFFF) link_age++;
			KIND_READ: begin
				e.channel  = req.data[3:0];
				e.link_ok  = link_up();
				e.value_us = e.link_ok ? pulse_store[req.data[3:0]] : cfg_failsafe;
				e.last     = 1'b1;
				pulse_q.push_back(e);
			end
			default: ;
		endcase
	endtask

	// monitor: results first, then the request taken at this edge, then register writes
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			req_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (pulse_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending, channel %0d",
						out_data.channel));
				end else begin
					want = pulse_q.pop_front();
					if (out_data.channel !== want.channel)
						report_mismatch($sformatf("channel got %0d want %0d",
							out_data.channel, want.channel));
					if (out_data.value_us !== want.value_us)
						report_mismatch($sformatf("ch %0d value_us got %0d want %0d",
							want.channel, out_data.value_us, want.value_us));
					if (out_data.link_ok !== want.link_ok)
						report_mismatch($sformatf("ch %0d link_ok got %b want %b",
							want.channel, out_data.link_ok, want.link_ok));
					if (out_data.last !== want.last)
						report_mismatch($sformatf("ch %0d last got %b want %b",
							want.channel, out_data.last, want.last));
				end
			end
			if (in_valid && in_ready) begin
				decode_request(in_data);
				n_taken++;
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SYNC:     cfg_sync     = pwdata[7:0];
					REG_TYPE:     cfg_type     = pwdata[7:0];
					REG_TIMEOUT:  cfg_timeout  = pwdata[15:0];
					REG_FAILSAFE: cfg_failsafe = pwdata[11:0];
					default: ;
				endcase
			end
		end
	end

	// sender: bursts of requests with random gaps
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			if (gap_left == 0 && request_q.size() != 0) begin
				in_valid <= 1'b1;
				in_data  <= request_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
				if (gap_left != 0)
					gap_left <= gap_left - 1;
			end
		end
	end

	// receiver: short stalls, switched off now and then
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (stall_mode && $urandom_range(0, 3) == 0)
				stall_left <= $urandom_range(1, 5);
		end
		if ($urandom_range(0, 199) == 0)
			stall_mode <= !stall_mode;
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] k, input logic [7:0] d);
		in_item_t it;
		it.kind = k;
		it.data = d;
		request_q.push_back(it);
		n_queued++;
	endtask

	task automatic push_frame(input int len, input logic [7:0] ftype, input int fill);
		int total;
		logic [7:0] b;
		if (len + 2 > FRAME_MEM)
			total = FRAME_MEM;
		else if (len < 1)
			total = 3;
		else
			total = len + 2;
		push_item(KIND_BYTE, sync_now);
		push_item(KIND_BYTE, len[7:0]);
		push_item(KIND_BYTE, ftype);
		for (int i = 3; i < total; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default:   b = 8'($urandom_range(0, 255));
			endcase
			push_item(KIND_BYTE, b);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_SYNC: sync_now = val[7:0];
			REG_TYPE: type_now = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] s, input logic [7:0] t,
			input logic [15:0] tmo, input logic [11:0] fs);
		write_reg(REG_SYNC, {24'd0, s});
		write_reg(REG_TYPE, {24'd0, t});
		write_reg(REG_TIMEOUT, {16'd0, tmo});
		write_reg(REG_FAILSAFE, {20'd0, fs});
	endtask

	// block idle: every request taken, every result back, then a margin
	task automatic settle();
		int wait_left;
		while (n_taken != n_queued)
			@(negedge clk);
		wait_left = DRAIN_LIMIT;
		while (pulse_q.size() != 0 && wait_left > 0) begin
			@(negedge clk);
			wait_left--;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pulse_q.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pulse_q.size()));
			pulse_q.delete();
		end
	endtask

	task automatic random_mix(input int budget);
		int pick;
		int mark;
		while (budget > 0) begin
			pick = $urandom_range(0, 99);
			mark = n_queued;
			if (pick < 35)
				push_frame(($urandom_range(0, 3) == 0) ? $urandom_range(22, 30) : 24,
					type_now, FILL_RAND);
			else if (pick < 45)
				push_frame($urandom_range(0, 22), type_now, $urandom_range(0, 2));
			else if (pick < 50)
				push_frame($urandom_range(0, 30), type_now ^ 8'($urandom_range(1, 255)),
					FILL_RAND);
			else if (pick < 52)
				push_frame($urandom_range(62, 255), type_now, FILL_RAND);
			else if (pick < 70)
				repeat ($urandom_range(1, 4))
					push_item(KIND_TICK, 8'($urandom_range(0, 255)));
			else if (pick < 88)
				repeat ($urandom_range(1, 3))
					push_item(KIND_READ, 8'($urandom_range(0, 255)));
			else if (pick < 94)
				push_item(KIND_BYTE, 8'($urandom_range(0, 255)));
			else begin
				push_item(KIND_SPARE, 8'($urandom_range(0, 255)));
				mark = n_queued;
			end
			budget -= n_queued - mark;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values, extremes of the payload, short and odd frames
		push_item(KIND_READ, 8'hF0);
		push_item(KIND_READ, 8'h0F);
		push_item(KIND_SPARE, 8'hA5);
		push_frame(24, TYPE_RST, FILL_ONES);
		push_item(KIND_READ, 8'h07);
		push_frame(0, TYPE_RST, FILL_RAND);
		push_frame(1, TYPE_RST, FILL_RAND);
		push_frame(24, TYPE_RST, FILL_ZERO);
		push_frame(5, TYPE_RST + 8'd1, FILL_ONES);
		push_frame(10, TYPE_RST, FILL_ONES);
		push_frame(63, TYPE_RST, FILL_RAND);
		push_frame(3, TYPE_RST, FILL_RAND);
		push_item(KIND_TICK, 8'hFF);
		push_item(KIND_READ, 8'h3C);
		settle();

		set_config(8'h00, 8'hFF, 16'd1, 12'd4095);
		random_mix(15);
		settle();

		// zero timeout: link never up
		set_config(8'hFF, 8'h00, 16'd0, 12'd0);
		random_mix(10);
		settle();

		// link drops once the age reaches the timeout, a new frame brings it back
		set_config(SYNC_RST, TYPE_RST, 16'd3, 12'($urandom_range(0, 4095)));
		push_frame(24, TYPE_RST, FILL_RAND);
		push_item(KIND_READ, 8'h01);
		repeat (2) push_item(KIND_TICK, 8'($urandom_range(0, 255)));
		push_item(KIND_READ, 8'h02);
		push_item(KIND_TICK, 8'h00);
		push_item(KIND_READ, 8'hEE);
		push_frame(24, TYPE_RST, FILL_RAND);
		push_item(KIND_READ, 8'h05);
		settle();

		repeat (2) begin
			set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				16'($urandom_range(1, 30)), 12'($urandom_range(0, 4095)));
			random_mix(8);
			settle();
		end

		if (n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
